[rtl/core/nrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrt_pkg
// Types and codes shared by the neighbor route table.
// ----------------------------------------------------------------------------
package nrt_pkg;

    localparam logic [7:0] HOPS_NONE = 8'd255;

    // op codes
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_PRUNE  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_HOPS = 2'd0;
    localparam logic [1:0] CFG_BEACON   = 2'd1;
    localparam logic [1:0] CFG_GAP      = 2'd2;
    localparam logic [1:0] CFG_ROLE     = 2'd3;

    // one neighbor entry as held in the table memory
    typedef struct packed {
        logic [31:0]        id;
        logic [7:0]         hops;
        logic signed [15:0] rssi;
        logic [31:0]        seen;
    } entry_t;

endpackage

[rtl/core/neighbor_route_table.sv]
`timescale 1ns / 1ps
// Each pass walks the table entry by entry. A rejected, clear or no-op word goes
// straight to the result state. An update on a full table walks the id search,
// the worst-entry search and route selection. One word at a time: the next word
// is taken only once the result of the last is loaded. Reset: synchronous; table
// empties, no route.
// ----------------------------------------------------------------------------
// neighbor_route_table
// Bounded mesh neighbor table with best/second-best route selection and an
// advertisement trigger, run by a small sequencer over a one-port memory.
// ----------------------------------------------------------------------------
module neighbor_route_table #(
    parameter int MAX_NEIGHBORS   = 8,
    parameter int TIMEOUT_BEACONS = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [31:0]        s_now_ms,
    input  logic [31:0]        s_neighbor_id,
    input  logic [7:0]         s_advertised_hops,
    input  logic signed [15:0] s_rssi,
    input  logic               s_retry_busy,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic [31:0]        m_best_id,
    output logic [31:0]        m_second_best_id,
    output logic [7:0]         m_own_hops,
    output logic               m_send_advert,
    output logic [3:0]         m_entry_count
);
    import nrt_pkg::*;

    localparam int IDX_W = $clog2(MAX_NEIGHBORS);
    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam int LIM_W = 32 + $clog2(TIMEOUT_BEACONS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NEIGHBORS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FRD    = 4'd1;
    localparam logic [3:0] S_FCHK   = 4'd2;
    localparam logic [3:0] S_WRD    = 4'd3;
    localparam logic [3:0] S_WCHK   = 4'd4;
    localparam logic [3:0] S_WDEC   = 4'd5;
    localparam logic [3:0] S_RRD    = 4'd6;
    localparam logic [3:0] S_RCHK   = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;
    localparam logic [3:0] S_PRD    = 4'd9;
    localparam logic [3:0] S_PCHK   = 4'd10;
    localparam logic [3:0] S_PLCHK  = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    // table memory, registered read
    entry_t mem [MAX_NEIGHBORS];
    entry_t rd_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [3:0]        state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  wi_reg;
    logic [7:0]        wh_reg;
    logic signed [15:0] wr_reg;
    logic              removed_reg;

    // latched item
    logic [31:0]        now_reg;
    logic [31:0]        id_reg;
    logic [7:0]         hops_reg;
    logic signed [15:0] rssi_reg;
    logic               busy_reg;

    // route search
    logic               hb_reg, hs_reg;
    logic [31:0]        bid_reg, sid_reg;
    logic [7:0]         bh_reg, sh_reg;
    logic signed [15:0] br_reg, sr_reg;

    // persistent route state and config
    logic [31:0] best_reg, second_reg, last_ms_reg;
    logic [7:0]  own_reg, last_hops_reg;
    logic [7:0]  min_hops_reg;
    logic [31:0] beacon_reg, gap_reg;
    logic        role_reg;
    logic [LIM_W-1:0] limit_reg;
    logic        status_reg, advert_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    // read address follows the pass in progress
    always_comb begin
        if (state_reg == S_PCHK) begin
            rd_addr = IDX_W'(count_reg - 1'b1);
        end else begin
            rd_addr = idx_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= mem[rd_addr];
    end

    // ranking helpers on the freshly read entry
    logic i_above_b, b_above_s, i_above_s, worse_w, new_better_w, timed_out;
    logic [31:0] age;
    always_comb begin
        i_above_b = (rd_reg.hops != bh_reg) ? (rd_reg.hops < bh_reg) : (rd_reg.rssi > br_reg);
        b_above_s = (bh_reg != sh_reg) ? (bh_reg < sh_reg) : (br_reg > sr_reg);
        i_above_s = (rd_reg.hops != sh_reg) ? (rd_reg.hops < sh_reg) : (rd_reg.rssi > sr_reg);
        worse_w   = (rd_reg.hops > wh_reg) ||
                    ((rd_reg.hops == wh_reg) && (rd_reg.rssi < wr_reg));
        new_better_w = (hops_reg < wh_reg) || ((hops_reg == wh_reg) && (rssi_reg > wr_reg));
        age       = now_reg - rd_reg.seen;
        timed_out = {{(LIM_W-32){1'b0}}, age} >= limit_reg;
    end

    // final route values and advert decision
    logic [31:0] fin_best, fin_second;
    logic [7:0]  fin_own;
    logic        fin_adv;
    always_comb begin
        if (hb_reg) begin
            fin_best   = bid_reg;
            fin_own    = bh_reg + 8'd1;
            fin_second = hs_reg ? sid_reg : bid_reg;
        end else begin
            fin_best   = 32'd0;
            fin_own    = HOPS_NONE;
            fin_second = 32'd0;
        end
        fin_adv = role_reg && (fin_own != last_hops_reg) &&
                  ((now_reg - last_ms_reg) >= gap_reg) &&
                  (count_reg != '0) && !busy_reg;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            best_reg      <= 32'd0;
            second_reg    <= 32'd0;
            own_reg       <= HOPS_NONE;
            last_hops_reg <= HOPS_NONE;
            last_ms_reg   <= 32'd0;
            min_hops_reg  <= 8'd0;
            beacon_reg    <= 32'd1000;
            gap_reg       <= 32'd0;
            role_reg      <= 1'b1;
            m_valid       <= 1'b0;
        end else begin
            // DONE reloads the result register itself
            if (m_valid && m_ready && state_reg != S_DONE) begin
                m_valid <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MIN_HOPS: min_hops_reg <= cfg_data[7:0];
                    CFG_BEACON:   beacon_reg   <= cfg_data;
                    CFG_GAP:      gap_reg      <= cfg_data;
                    CFG_ROLE:     role_reg     <= cfg_data[0];
                    default:      ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        now_reg     <= s_now_ms;
                        id_reg      <= s_neighbor_id;
                        hops_reg    <= s_advertised_hops;
                        rssi_reg    <= s_rssi;
                        busy_reg    <= s_retry_busy;
                        idx_reg     <= '0;
                        status_reg  <= 1'b0;
                        advert_reg  <= 1'b0;
                        removed_reg <= 1'b0;
                        hb_reg      <= 1'b0;
                        hs_reg      <= 1'b0;
                        limit_reg   <= LIM_W'(beacon_reg) * LIM_W'(TIMEOUT_BEACONS);
                        case (s_op)
                            OP_UPDATE: state_reg <= (s_advertised_hops >= min_hops_reg)
                                                    ? S_FRD : S_DONE;
                            OP_PRUNE:  state_reg <= S_PRD;
                            OP_CLEAR: begin
                                count_reg  <= '0;
                                best_reg   <= 32'd0;
                                second_reg <= 32'd0;
                                own_reg    <= HOPS_NONE;
                                state_reg  <= S_DONE;
                            end
                            default:   state_reg <= S_DONE;
                        endcase
                    end
                end
                // look for the id
                S_FRD: begin
                    if (idx_reg < count_reg) begin
                        state_reg <= S_FCHK;
                    end else if (count_reg >= CNT_MAX) begin
                        idx_reg   <= '0;
                        state_reg <= S_WRD;
                    end else begin
                        mem[count_reg[IDX_W-1:0]] <= '{id_reg, hops_reg, rssi_reg, now_reg};
                        count_reg <= count_reg + 1'b1;
                        idx_reg   <= '0;
                        state_reg <= S_RRD;
                    end
                end
                S_FCHK: begin
                    if (rd_reg.id == id_reg) begin
                        mem[idx_reg[IDX_W-1:0]] <= '{id_reg, hops_reg, rssi_reg, now_reg};
                        idx_reg   <= '0;
                        state_reg <= S_RRD;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_FRD;
                    end
                end
                // find first worst entry of a full table
                S_WRD: begin
                    state_reg <= (idx_reg < CNT_MAX) ? S_WCHK : S_WDEC;
                end
                S_WCHK: begin
                    if (idx_reg == '0 || worse_w) begin
                        wi_reg <= idx_reg[IDX_W-1:0];
                        wh_reg <= rd_reg.hops;
                        wr_reg <= rd_reg.rssi;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_WRD;
                end
                S_WDEC: begin
                    idx_reg <= '0;
                    if (new_better_w) begin
                        mem[wi_reg] <= '{id_reg, hops_reg, rssi_reg, now_reg};
                        state_reg   <= S_RRD;
                    end else begin
                        status_reg <= 1'b1;
                        state_reg  <= S_DONE;
                    end
                end
                // best and second-best pass
                S_RRD: begin
                    state_reg <= (idx_reg < count_reg) ? S_RCHK : S_FIN;
                end
                S_RCHK: begin
                    if (rd_reg.hops != HOPS_NONE) begin
                        if (!hb_reg) begin
                            hb_reg  <= 1'b1;
                            bid_reg <= rd_reg.id;
                            bh_reg  <= rd_reg.hops;
                            br_reg  <= rd_reg.rssi;
                        end else if (i_above_b) begin
                            if (!hs_reg || b_above_s) begin
                                hs_reg  <= 1'b1;
                                sid_reg <= bid_reg;
                                sh_reg  <= bh_reg;
                                sr_reg  <= br_reg;
                            end
                            bid_reg <= rd_reg.id;
                            bh_reg  <= rd_reg.hops;
                            br_reg  <= rd_reg.rssi;
                        end else if (!hs_reg || i_above_s) begin
                            hs_reg  <= 1'b1;
                            sid_reg <= rd_reg.id;
                            sh_reg  <= rd_reg.hops;
                            sr_reg  <= rd_reg.rssi;
                        end
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_RRD;
                end
                S_FIN: begin
                    best_reg   <= fin_best;
                    second_reg <= fin_second;
                    own_reg    <= fin_own;
                    advert_reg <= fin_adv;
                    if (fin_adv) begin
                        last_hops_reg <= fin_own;
                        last_ms_reg   <= now_reg;
                    end
                    state_reg <= S_DONE;
                end
                // prune pass, swap-remove from the tail
                S_PRD: begin
                    if (idx_reg < count_reg) begin
                        state_reg <= S_PCHK;
                    end else if (removed_reg) begin
                        idx_reg   <= '0;
                        state_reg <= S_RRD;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_PCHK: begin
                    if (timed_out) begin
                        state_reg <= S_PLCHK;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_PRD;
                    end
                end
                S_PLCHK: begin
                    mem[idx_reg[IDX_W-1:0]] <= rd_reg;
                    count_reg   <= count_reg - 1'b1;
                    removed_reg <= 1'b1;
                    state_reg   <= S_PRD;
                end
                S_DONE: begin
                    if (!m_valid || m_ready) begin
                        m_valid          <= 1'b1;
                        m_status         <= status_reg;
                        m_best_id        <= best_reg;
                        m_second_best_id <= second_reg;
                        m_own_hops       <= own_reg;
                        m_send_advert    <= advert_reg;
                        m_entry_count    <= 4'(count_reg);
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX) else $error("entry count above table size");
    a_drop_no_advert: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> !m_send_advert) else $error("advert on dropped word");
    a_advert_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && fin_adv) |=> (last_hops_reg == own_reg))
        else $error("last advert hops not stored");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE)) else $error("item lost");

endmodule

[tb/neighbor_route_table_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_route_table_test
// Self-checking bench for the neighbor route table. A directed table of words
// covers the corner cases, then random traffic runs under four register
// settings, with random idling on both channels and one long result stall.
// Every result word is checked field by field against a cycle-free model of
// the table kept inside the bench, or against the fixed result of its row.
// ----------------------------------------------------------------------------
module neighbor_route_table_test;
    import nrt_pkg::*;

    localparam int SLOTS       = 8;
    localparam int BEACON_MULT = 3;
    localparam int SETTLE      = 60;
    localparam int IDLE_LIMIT  = 5000;
    localparam int RAND_WORDS  = 580;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic        status;
        logic [31:0] best;
        logic [31:0] second;
        logic [7:0]  own;
        logic        advert;
        logic [3:0]  count;
    } route_word_t;

    typedef struct {
        logic [1:0]         op;
        logic [31:0]        now;
        logic [31:0]        id;
        logic [7:0]         hops;
        logic signed [15:0] rssi;
        logic               busy;
        logic               fixed;
        route_word_t        res;
    } stim_row_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_op = OP_UPDATE;
    logic [31:0]        s_now_ms = '0;
    logic [31:0]        s_neighbor_id = '0;
    logic [7:0]         s_advertised_hops = '0;
    logic signed [15:0] s_rssi = '0;
    logic               s_retry_busy = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_status;
    logic [31:0]        m_best_id;
    logic [31:0]        m_second_best_id;
    logic [7:0]         m_own_hops;
    logic               m_send_advert;
    logic [3:0]         m_entry_count;

    // typed expectation travels with the word it belongs to
    logic               row_fixed = 1'b0;
    route_word_t        row_res = '0;

    neighbor_route_table u_dut (.*);

    // model of the table
    logic [31:0]        nb_id   [SLOTS];
    logic [7:0]         nb_hops [SLOTS];
    logic signed [15:0] nb_rssi [SLOTS];
    logic [31:0]        nb_seen [SLOTS];
    int                 nb_count;
    logic [31:0]        route_best, route_second;
    logic [7:0]         route_own, adv_hops;
    logic [31:0]        adv_ms;
    logic [7:0]         reg_min_hops;
    logic [31:0]        reg_beacon, reg_gap;
    logic               reg_role;

    route_word_t        route_q[$];
    int                 errors = 0;
    int                 n_words = 0, n_drops = 0, n_adverts = 0, n_results = 0;
    int                 send_idle_pct = 0, recv_idle_pct = 0;
    int                 stall_left = 0;
    int                 quiet_cycles = 0;
    logic [31:0]        clock_ms = 0;
    stim_row_t          rows[$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit ranks_over(int a, int b);
        if (nb_hops[a] != nb_hops[b])
            return nb_hops[a] < nb_hops[b];
        return nb_rssi[a] > nb_rssi[b];
    endfunction

    // best / second best, skipping unreachable entries
    function automatic void pick_route();
        bit have_b = 0, have_s = 0;
        int b = 0, s = 0;
        for (int i = 0; i < nb_count; i++) begin
            if (nb_hops[i] == HOPS_NONE)
                continue;
            if (!have_b) begin
                b = i;
                have_b = 1;
            end else if (ranks_over(i, b)) begin
                if (!have_s || ranks_over(b, s)) begin
                    s = b;
                    have_s = 1;
                end
                b = i;
            end else if (!have_s || ranks_over(i, s)) begin
                s = i;
                have_s = 1;
            end
        end
        if (!have_b) begin
            route_best = 0;
            route_second = 0;
            route_own = HOPS_NONE;
        end else begin
            route_best = nb_id[b];
            route_own = nb_hops[b] + 8'd1;
            route_second = have_s ? nb_id[s] : nb_id[b];
        end
    endfunction

    function automatic logic advert_due(logic [31:0] now, logic busy);
        logic [31:0] gap;
        gap = now - adv_ms;
        if (!reg_role || route_own == adv_hops || gap < reg_gap || nb_count == 0 || busy)
            return 1'b0;
        adv_hops = route_own;
        adv_ms = now;
        return 1'b1;
    endfunction

    function automatic void put_entry(int k, logic [31:0] id, logic [7:0] hops,
                                      logic signed [15:0] rssi, logic [31:0] seen);
        nb_id[k] = id;
        nb_hops[k] = hops;
        nb_rssi[k] = rssi;
        nb_seen[k] = seen;
    endfunction

    // one accepted input word -> its result word
    function automatic route_word_t table_step(logic [1:0] op, logic [31:0] now,
            logic [31:0] id, logic [7:0] hops, logic signed [15:0] rssi, logic busy);
        route_word_t r;
        bit found, changed, removed;
        int w, i, last;
        logic [63:0] lim;
        logic [31:0] age;
        r = '0;
        if (op == OP_UPDATE && hops >= reg_min_hops) begin
            found = 0;
            changed = 1;
            for (i = 0; i < nb_count; i++)
                if (nb_id[i] == id) begin
                    put_entry(i, id, hops, rssi, now);
                    found = 1;
                    break;
                end
            if (!found) begin
                if (nb_count >= SLOTS) begin
                    // first worst: most hops, then lowest rssi
                    w = 0;
                    for (i = 1; i < SLOTS; i++)
                        if (nb_hops[i] > nb_hops[w] ||
                            (nb_hops[i] == nb_hops[w] && nb_rssi[i] < nb_rssi[w]))
                            w = i;
                    if (hops < nb_hops[w] || (hops == nb_hops[w] && rssi > nb_rssi[w]))
                        put_entry(w, id, hops, rssi, now);
                    else begin
                        r.status = 1'b1;
                        changed = 0;
                    end
                end else begin
                    put_entry(nb_count, id, hops, rssi, now);
                    nb_count++;
                end
            end
            if (changed) begin
                pick_route();
                r.advert = advert_due(now, busy);
            end
        end else if (op == OP_PRUNE) begin
            lim = {32'd0, reg_beacon} * BEACON_MULT;
            removed = 0;
            i = 0;
            // swap-remove, recheck the refilled slot
            while (i < nb_count) begin
                age = now - nb_seen[i];
                if ({32'd0, age} >= lim) begin
                    last = nb_count - 1;
                    put_entry(i, nb_id[last], nb_hops[last], nb_rssi[last], nb_seen[last]);
                    nb_count--;
                    removed = 1;
                end else
                    i++;
            end
            if (removed) begin
                pick_route();
                r.advert = advert_due(now, busy);
            end
        end else if (op == OP_CLEAR) begin
            nb_count = 0;
            route_best = 0;
            route_second = 0;
            route_own = HOPS_NONE;
        end
        r.best = route_best;
        r.second = route_second;
        r.own = route_own;
        r.count = nb_count[3:0];
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        errors++;
    endtask

    // input side: predict on acceptance
    always @(posedge aclk) begin
        route_word_t p;
        if (aresetn && s_valid && s_ready) begin
            p = table_step(s_op, s_now_ms, s_neighbor_id, s_advertised_hops, s_rssi,
                           s_retry_busy);
            n_words++;
            n_drops += p.status;
            n_adverts += p.advert;
            route_q.push_back(row_fixed ? row_res : p);
        end
    end

    // configuration side
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MIN_HOPS: reg_min_hops = cfg_data[7:0];
                CFG_BEACON:   reg_beacon = cfg_data;
                CFG_GAP:      reg_gap = cfg_data;
                CFG_ROLE:     reg_role = cfg_data[0];
            endcase
        end
    end

    // result side: compare with oldest expectation
    always @(posedge aclk) begin
        route_word_t e;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (route_q.size() == 0) begin
                $display("%0t: result word with nothing expected", $time);
                errors++;
            end else begin
                e = route_q.pop_front();
                if (m_status !== e.status) report("status", m_status, e.status);
                if (m_best_id !== e.best) report("best_id", m_best_id, e.best);
                if (m_second_best_id !== e.second)
                    report("second_best_id", m_second_best_id, e.second);
                if (m_own_hops !== e.own) report("own_hops", m_own_hops, e.own);
                if (m_send_advert !== e.advert)
                    report("send_advert", m_send_advert, e.advert);
                if (m_entry_count !== e.count) report("entry_count", m_entry_count, e.count);
            end
        end
    end

    // receiver: random back-pressure, plus a long hold when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else if (++quiet_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic drain();
        while (route_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_regs(logic [7:0] mh, logic [31:0] bi, logic [31:0] gap, logic role);
        drain();
        write_reg(CFG_MIN_HOPS, {24'd0, mh});
        write_reg(CFG_BEACON, bi);
        write_reg(CFG_GAP, gap);
        write_reg(CFG_ROLE, {31'd0, role});
    endtask

    // offer one word, hold until taken; called at a clock edge
    task automatic send_word(stim_row_t r);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_op <= r.op;
        s_now_ms <= r.now;
        s_neighbor_id <= r.id;
        s_advertised_hops <= r.hops;
        s_rssi <= r.rssi;
        s_retry_busy <= r.busy;
        row_fixed <= r.fixed;
        row_res <= r.res;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic add_row(logic [1:0] op, logic [31:0] now, logic [31:0] id,
                           logic [7:0] hops, logic signed [15:0] rssi, logic busy,
                           logic fixed = 1'b0, route_word_t res = '0);
        stim_row_t r;
        r.op = op; r.now = now; r.id = id; r.hops = hops;
        r.rssi = rssi; r.busy = busy; r.fixed = fixed; r.res = res;
        rows.push_back(r);
    endtask

    // random word: mostly updates from a small id pool so the table fills
    function automatic stim_row_t rand_word();
        stim_row_t r;
        int k;
        k = $urandom_range(99);
        r.op = (k < 70) ? OP_UPDATE : (k < 90) ? OP_PRUNE : (k < 95) ? OP_CLEAR : OP_NOP;
        k = $urandom_range(99);
        if (k < 3)
            clock_ms = $urandom;
        else
            clock_ms += $urandom_range(400);
        r.now = clock_ms;
        r.id = ($urandom_range(9) == 0) ? $urandom : $urandom_range(12);
        k = $urandom_range(99);
        r.hops = (k < 75) ? 8'($urandom_range(8)) : (k < 85) ? 8'($urandom_range(255, 252))
                                                  : 8'($urandom);
        r.rssi = 16'($urandom);
        r.busy = ($urandom_range(3) == 0);
        r.fixed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    initial begin
        route_word_t empty_res;
        empty_res = '{status: 1'b0, best: 0, second: 0, own: HOPS_NONE, advert: 1'b0,
                      count: 4'd0};
        for (int i = 0; i < SLOTS; i++)
            put_entry(i, 0, 0, 0, 0);
        nb_count = 0;
        route_best = 0; route_second = 0; route_own = HOPS_NONE;
        adv_hops = HOPS_NONE; adv_ms = 0;
        reg_min_hops = 0; reg_beacon = 1000; reg_gap = 0; reg_role = 1'b1;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, extremes, full table, timeouts, clear
        add_row(OP_PRUNE, 0, 0, 0, 0, 0, 1'b1, empty_res);
        add_row(OP_UPDATE, 10, 1, 0, 100, 0, 1'b1,
                '{status: 1'b0, best: 1, second: 1, own: 8'd1, advert: 1'b1, count: 4'd1});
        add_row(OP_UPDATE, 20, 32'hFFFF_FFFF, 0, 16'sh7FFF, 1);
        add_row(OP_UPDATE, 30, 0, 254, -16'sd32768, 0);
        add_row(OP_UPDATE, 40, 4, HOPS_NONE, 0, 0);
        add_row(OP_UPDATE, 41, 5, 3, -16'sd50, 0);
        add_row(OP_UPDATE, 42, 6, 3, -16'sd50, 0);
        add_row(OP_UPDATE, 43, 7, 3, 16'sd20, 0);
        add_row(OP_UPDATE, 44, 8, 7, 16'sd1, 0);
        add_row(OP_UPDATE, 45, 9, HOPS_NONE, 16'sd5, 0);
        add_row(OP_UPDATE, 46, 10, HOPS_NONE, -16'sd32768, 0);
        add_row(OP_UPDATE, 47, 11, 3, -16'sd50, 0);
        add_row(OP_UPDATE, 50, 1, 2, -16'sd5, 0);
        add_row(OP_NOP, 60, 3, 3, 3, 1);
        add_row(OP_PRUNE, 2000, 0, 0, 0, 0);
        add_row(OP_PRUNE, 3030, 0, 0, 0, 0);
        add_row(OP_PRUNE, 32'hFFFF_FFF0, 0, 0, 0, 0);
        add_row(OP_UPDATE, 100, 12, 254, 16'sd1, 0);
        add_row(OP_UPDATE, 101, 13, 254, 16'sd2, 0);
        add_row(OP_CLEAR, 102, 0, 0, 0, 0, 1'b1, empty_res);
        add_row(OP_UPDATE, 103, 14, 0, 0, 0);

        send_idle_pct = 29;
        recv_idle_pct = 50;
        foreach (rows[i])
            send_word(rows[i]);
        s_valid <= 1'b0;
        row_fixed <= 1'b0;

        // random phases under several register settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_regs(8'd0, 32'd1000, 32'd0, 1'b1);
                1: set_regs(8'd3, 32'd0, 32'd500, 1'b0);
                2: set_regs(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
                default: set_regs(8'($urandom_range(4)), $urandom_range(2000, 50),
                                  $urandom_range(300), 1'b1);
            endcase
            send_idle_pct = (ph < 2) ? 29 : (ph == 2) ? 50 : 0;
            recv_idle_pct = (ph < 2) ? 50 : (ph == 2) ? 29 : 0;
            if (ph == 3)
                stall_left = 400;
            // the phase with the highest minimum hop count carries fewer words
            for (int n = 0; n < ((ph == 2) ? 150 : RAND_WORDS); n++) begin
                stim_row_t r;
                r = rand_word();
                if (ph == 2 && r.op == OP_UPDATE && $urandom_range(1))
                    r.hops = 8'd255;
                send_word(r);
            end
            s_valid <= 1'b0;
        end

        drain();
        $display("covered %0d words, %0d results, %0d drops on a full table, %0d adverts",
                 n_words, n_results, n_drops, n_adverts);
        $display("four register settings, idling on both sides and a long result stall");
        if (errors == 0 && route_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/nrt_pkg.sv
rtl/core/neighbor_route_table.sv
tb/neighbor_route_table_test.sv
